// ----- sv/gte_pkg.sv -----
// ----------------------------------------------------------------------------
// gte_pkg
// Shared types and constants of the graph traversal engine: word formats,
// opcodes, status codes, sequencer states and storage request bundles.
// ----------------------------------------------------------------------------
package gte_pkg;

  // Sizing
  localparam int MaxVertices = 64;
  localparam int MaxDegree   = 8;
  localparam int VtxW        = 6;                        // vertex number
  localparam int SlotW       = $clog2(MaxDegree);        // slot within a list
  localparam int DegW        = $clog2(MaxDegree + 1);    // list length 0..MaxDegree
  localparam int CntW        = 7;                        // vertex_count, worklist fill
  localparam int NtDepth     = MaxVertices * MaxDegree;
  localparam int NtAddrW     = $clog2(NtDepth);

  // Opcodes of an input word
  typedef enum logic [1:0] {
    OpClear    = 2'd0,
    OpAppend   = 2'd1,
    OpTraverse = 2'd2,
    OpIgnore   = 2'd3
  } op_e;

  // Status codes of a result word
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2
  } status_e;

  // Configuration register indexes
  localparam logic CfgOrder  = 1'b0;
  localparam logic CfgVcount = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    SqIdle,
    SqAppRd,
    SqEmit,
    SqPop,
    SqCur,
    SqDeg,
    SqScan,
    SqNbr,
    SqFinish
  } seq_state_e;

  // Input word
  typedef struct packed {
    logic [1:0]      op;
    logic [VtxW-1:0] vertex;
    logic [VtxW-1:0] neighbor;
  } gte_in_t;

  // Result word
  typedef struct packed {
    logic [VtxW-1:0] visited_vertex;
    logic [1:0]      status;
    logic            last;
  } gte_out_t;

  // Requests to the storage block
  typedef struct packed {
    logic               deg_clr;
    logic [VtxW-1:0]    deg_addr;
    logic               deg_we;
    logic [DegW-1:0]    deg_wdata;
    logic [NtAddrW-1:0] nt_addr;
    logic               nt_we;
    logic [VtxW-1:0]    nt_wdata;
    logic [VtxW-1:0]    wl_raddr;
    logic               wl_we;
    logic [VtxW-1:0]    wl_waddr;
    logic [VtxW-1:0]    wl_wdata;
  } gte_mem_req_t;

  // Registered read data from the storage block
  typedef struct packed {
    logic [DegW-1:0] deg;
    logic [VtxW-1:0] nt;
    logic [VtxW-1:0] wl;
  } gte_mem_rsp_t;

endpackage

// ----- sv/gte_mem.sv -----
// ----------------------------------------------------------------------------
// gte_mem
// Storage of the engine: adjacency table, per-vertex list lengths with
// valid bits, and the worklist. All reads are registered.
// ----------------------------------------------------------------------------
module gte_mem import gte_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gte_mem_req_t req_i,
  output gte_mem_rsp_t rsp_o
);

  logic [VtxW-1:0]        nt_mem  [NtDepth];
  logic [DegW-1:0]        deg_mem [MaxVertices];
  logic [VtxW-1:0]        wl_mem  [MaxVertices];
  logic [MaxVertices-1:0] deg_vld_q;

  logic [VtxW-1:0] nt_rd_q;
  logic [VtxW-1:0] wl_rd_q;
  logic [DegW-1:0] deg_rd_q;
  logic            deg_rd_vld_q;

  // Adjacency table: one port, write or read
  always_ff @(posedge clk_i) begin
    if (req_i.nt_we) begin
      nt_mem[req_i.nt_addr] <= req_i.nt_wdata;
    end
    nt_rd_q <= nt_mem[req_i.nt_addr];
  end

  // Worklist: one write port, one read port
  always_ff @(posedge clk_i) begin
    if (req_i.wl_we) begin
      wl_mem[req_i.wl_waddr] <= req_i.wl_wdata;
    end
    wl_rd_q <= wl_mem[req_i.wl_raddr];
  end

  // List lengths: data without reset, validity tracked in flops
  always_ff @(posedge clk_i) begin
    if (req_i.deg_we) begin
      deg_mem[req_i.deg_addr] <= req_i.deg_wdata;
    end
    deg_rd_q <= deg_mem[req_i.deg_addr];
  end

  // Clear every length at once on reset or graph clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_vld_q    <= '0;
      deg_rd_vld_q <= 1'b0;
    end else begin
      deg_rd_vld_q <= deg_vld_q[req_i.deg_addr];
      if (req_i.deg_clr) begin
        deg_vld_q <= '0;
      end else if (req_i.deg_we) begin
        deg_vld_q[req_i.deg_addr] <= 1'b1;
      end
    end
  end

  // An entry never written reads as an empty list
  assign rsp_o.deg = deg_rd_vld_q ? deg_rd_q : '0;
  assign rsp_o.nt  = nt_rd_q;
  assign rsp_o.wl  = wl_rd_q;

endmodule

// ----- sv/graph_traversal_engine_core.sv -----
// ----------------------------------------------------------------------------
// graph_traversal_engine_core
// Adjacency-list store with a depth-first (stack) or breadth-first (queue)
// walk, run by a small sequencer over one shared set of memories.
// ----------------------------------------------------------------------------
//
//   channel  | signals                               | word
//   ---------+---------------------------------------+--------------------
//   input    | in_valid_i / in_ready_o / in_data_i   | op, vertex, neighbor
//   result   | out_valid_o / out_ready_i / out_data_o| vertex, status, last
//   config   | cfg_we_i / cfg_idx_i / cfg_data_i     | order, vertex_count
//
// Clear and an out-of-range append or traverse go straight to the result;
// an ignored op gives none. An in-range append first reads the list length.
// A traverse pops each vertex, reads its list length and scans its list: every edge
// is one adjacency-table read and one worklist/visited update.
// Input is taken only while the sequencer is idle; a full result register
// holds the sequencer until the word is taken.
// Reset clears control state, the list lengths and the visited marks.
// ----------------------------------------------------------------------------
module graph_traversal_engine_core import gte_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gte_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gte_out_t        out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CntW-1:0] cfg_data_i
);

  seq_state_e state_q, state_d;

  logic                   order_q;
  logic [CntW-1:0]        vcnt_q;
  logic [CntW-1:0]        vcnt_eff;

  logic [VtxW-1:0]        v_q;
  logic [VtxW-1:0]        nb_q;
  logic [1:0]             st_q;
  logic [VtxW-1:0]        cur_q;
  logic [DegW-1:0]        deg_q;
  logic [SlotW-1:0]       slot_q;
  logic [VtxW-1:0]        head_q;
  logic [CntW-1:0]        count_q;
  logic [MaxVertices-1:0] visited_q;

  logic                   out_valid_q;
  gte_out_t               out_q;

  gte_mem_req_t           mreq;
  gte_mem_rsp_t           mrsp;

  logic                   in_acc;
  logic                   out_free;
  logic                   v_ok;
  logic                   nb_ok;
  logic                   w_push;
  logic                   deg_room;
  logic                   slot_end;
  logic [CntW-1:0]        count_dec;
  op_e                    in_op;

  gte_mem u_mem (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  // Effective vertex count, saturated at the table size
  assign vcnt_eff = (vcnt_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vcnt_q;

  assign in_op     = op_e'(in_data_i.op);
  assign in_ready_o = (state_q == SqIdle);
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign v_ok      = {1'b0, in_data_i.vertex} < vcnt_eff;
  assign nb_ok     = {1'b0, in_data_i.neighbor} < vcnt_eff;
  assign w_push    = ({1'b0, mrsp.nt} < vcnt_eff) && !visited_q[mrsp.nt];
  assign deg_room  = mrsp.deg < DegW'(MaxDegree);
  assign slot_end  = ({1'b0, slot_q} + DegW'(1)) == deg_q;
  assign count_dec = count_q - CntW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SqIdle: begin
        if (in_acc) begin
          case (in_op)
            OpClear:    state_d = SqEmit;
            OpAppend:   state_d = (v_ok && nb_ok) ? SqAppRd : SqEmit;
            OpTraverse: state_d = v_ok ? SqPop : SqEmit;
            default:    state_d = SqIdle;
          endcase
        end
      end
      SqAppRd:  state_d = SqEmit;
      SqEmit:   if (out_free) state_d = SqIdle;
      SqPop:    state_d = SqCur;
      SqCur:    state_d = SqDeg;
      SqDeg:    state_d = (mrsp.deg == '0) ? SqFinish : SqScan;
      SqScan:   state_d = SqNbr;
      SqNbr:    state_d = slot_end ? SqFinish : SqScan;
      SqFinish: begin
        if (out_free) begin
          state_d = (count_q == '0) ? SqIdle : SqPop;
        end
      end
      default:  state_d = SqIdle;
    endcase
  end

  // Storage requests
  always_comb begin
    mreq = '0;
    case (state_q)
      SqIdle: begin
        mreq.deg_addr = in_data_i.vertex;
        if (in_acc && in_op == OpClear) begin
          mreq.deg_clr = 1'b1;
        end
        if (in_acc && in_op == OpTraverse && v_ok) begin
          mreq.wl_we    = 1'b1;
          mreq.wl_waddr = '0;
          mreq.wl_wdata = in_data_i.vertex;
        end
      end
      SqAppRd: begin
        mreq.deg_addr  = v_q;
        mreq.deg_wdata = mrsp.deg + DegW'(1);
        mreq.nt_addr   = {v_q, mrsp.deg[SlotW-1:0]};
        mreq.nt_wdata  = nb_q;
        mreq.deg_we    = deg_room;
        mreq.nt_we     = deg_room;
      end
      SqPop: begin
        mreq.wl_raddr = order_q ? head_q : count_dec[VtxW-1:0];
      end
      SqCur: begin
        mreq.deg_addr = mrsp.wl;
      end
      SqScan: begin
        mreq.nt_addr = {cur_q, slot_q};
      end
      SqNbr: begin
        mreq.wl_we    = w_push;
        mreq.wl_waddr = order_q ? (head_q + count_q[VtxW-1:0]) : count_q[VtxW-1:0];
        mreq.wl_wdata = mrsp.nt;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
      vcnt_q  <= CntW'(MaxVertices);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOrder:  order_q <= cfg_data_i[0];
        CfgVcount: vcnt_q  <= cfg_data_i;
        default:   order_q <= order_q;
      endcase
    end
  end

  // Sequencer control and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SqIdle;
      head_q    <= '0;
      count_q   <= '0;
      visited_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        SqIdle: begin
          // Start a walk: only the start vertex is marked
          if (in_acc && in_op == OpTraverse && v_ok) begin
            head_q    <= '0;
            count_q   <= CntW'(1);
            visited_q <= MaxVertices'(1) << in_data_i.vertex;
          end
        end
        SqPop: begin
          count_q <= count_dec;
          if (order_q) begin
            head_q <= head_q + VtxW'(1);
          end
        end
        SqNbr: begin
          if (w_push) begin
            count_q <= count_q + CntW'(1);
            visited_q[mrsp.nt] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Word fields and walk pointers
  always_ff @(posedge clk_i) begin
    case (state_q)
      SqIdle: begin
        if (in_acc) begin
          v_q  <= in_data_i.vertex;
          nb_q <= in_data_i.neighbor;
          st_q <= (in_op == OpClear) ? StOk : StRange;
        end
      end
      SqAppRd: st_q <= deg_room ? StOk : StFull;
      SqCur:   cur_q <= mrsp.wl;
      SqDeg: begin
        deg_q  <= mrsp.deg;
        slot_q <= '0;
      end
      SqNbr:   slot_q <= slot_q + SlotW'(1);
      default: begin
      end
    endcase
  end

  // Result register: load from the sequencer, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= (state_q == SqEmit) || (state_q == SqFinish);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (state_q == SqEmit) begin
        out_q.visited_vertex <= '0;
        out_q.status         <= st_q;
        out_q.last           <= 1'b1;
      end else if (state_q == SqFinish) begin
        out_q.visited_vertex <= cur_q;
        out_q.status         <= StOk;
        out_q.last           <= (count_q == '0);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/gte_checker.sv -----
// ----------------------------------------------------------------------------
// gte_checker
// Port-level checks of the graph traversal engine, bound to the top level.
// ----------------------------------------------------------------------------
module gte_checker import gte_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input gte_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input gte_out_t out_data_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Error results carry no vertex and close their item
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |->
      out_data_o.visited_vertex == '0 && out_data_o.last)
    else $error("error result with vertex or without last");

  // Never show an undefined status code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= StRange)
    else $error("undefined status code");

  // An ignored op leaves the input open right away
  a_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.op == OpIgnore |=> in_ready_o)
    else $error("ignored op blocked input");

  // Any real op closes the input in the cycle after it is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.op != OpIgnore |=> !in_ready_o)
    else $error("input taken while an item was in work");

endmodule

bind graph_traversal_engine_core gte_checker u_gte_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ----- bench/gte_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// gte_tb_pkg
// Result predictor and scoreboard for the graph traversal engine. It keeps
// its own copy of the adjacency lists and the settings. It works out the
// status word or the visit order for each accepted input word. It then
// checks each result word against the oldest pending one.
// ----------------------------------------------------------------------------
package gte_tb_pkg;
  import gte_pkg::*;

  class traversal_scoreboard;
    bit              walk_bfs;
    bit [CntW-1:0]   vertex_limit;
    logic [VtxW-1:0] adjacency [MaxVertices][MaxDegree];
    int unsigned     list_len [MaxVertices];
    bit              seen [MaxVertices];
    gte_out_t        due_words [$];
    int              error_count;

    function new();
      walk_bfs     = 1'b0;
      vertex_limit = CntW'(MaxVertices);
      foreach (list_len[i]) list_len[i] = 0;
      foreach (seen[i]) seen[i] = 1'b0;
      error_count  = 0;
    endfunction

    function void write_reg(logic idx, logic [CntW-1:0] data);
      if (idx == CfgOrder) begin
        walk_bfs = data[0];
      end else begin
        vertex_limit = data;
      end
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void add_result(logic [VtxW-1:0] v, status_e st, bit lst);
      gte_out_t w;
      w.visited_vertex = v;
      w.status         = st;
      w.last           = lst;
      due_words.push_back(w);
    endfunction

    // Predict the result words of one accepted input word
    function void note_word(gte_in_t w);
      int unsigned     live;
      logic [VtxW-1:0] worklist [$];
      logic [VtxW-1:0] cur;
      logic [VtxW-1:0] nb;
      live = (vertex_limit > MaxVertices) ? MaxVertices : vertex_limit;
      case (op_e'(w.op))
        OpClear: begin
          foreach (list_len[i]) list_len[i] = 0;
          add_result('0, StOk, 1'b1);
        end
        OpAppend: begin
          if (w.vertex >= live || w.neighbor >= live) begin
            add_result('0, StRange, 1'b1);
          end else if (list_len[w.vertex] >= MaxDegree) begin
            add_result('0, StFull, 1'b1);
          end else begin
            adjacency[w.vertex][list_len[w.vertex]] = w.neighbor;
            list_len[w.vertex]++;
            add_result('0, StOk, 1'b1);
          end
        end
        OpTraverse: begin
          if (w.vertex >= live) begin
            add_result('0, StRange, 1'b1);
          end else begin
            // Mark on push; stack pops the newest, queue the oldest
            foreach (seen[i]) seen[i] = 1'b0;
            worklist.push_back(w.vertex);
            seen[w.vertex] = 1'b1;
            while (worklist.size() > 0) begin
              cur = walk_bfs ? worklist.pop_front() : worklist.pop_back();
              for (int j = 0; j < list_len[cur]; j++) begin
                nb = adjacency[cur][j];
                // Skip stale entries at or above the current vertex count
                if (nb < live && !seen[nb]) begin
                  worklist.push_back(nb);
                  seen[nb] = 1'b1;
                end
              end
              add_result(cur, StOk, worklist.size() == 0);
            end
          end
        end
        default: begin
          // Ignored op: no result word
        end
      endcase
    endfunction

    function void report_field(string name, int unsigned exp_v, int unsigned got_v,
                               longint unsigned now);
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", now, name, exp_v, got_v);
    endfunction

    // Compare one accepted result word with the oldest pending word
    function void check_word(gte_out_t got, longint unsigned now);
      gte_out_t exp_w;
      if (due_words.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result word, expected none, actual %h", now, got);
        return;
      end
      exp_w = due_words.pop_front();
      if (got.visited_vertex !== exp_w.visited_vertex)
        report_field("visited_vertex", exp_w.visited_vertex, got.visited_vertex, now);
      if (got.status !== exp_w.status)
        report_field("status", exp_w.status, got.status, now);
      if (got.last !== exp_w.last)
        report_field("last", exp_w.last, got.last, now);
    endfunction

    // Count every word still pending at the end of the run
    function void flush_leftovers(longint unsigned now);
      while (due_words.size() > 0) begin
        error_count++;
        $display("%0t ns: missing result word, expected %h, actual none", now,
                 due_words[0]);
        void'(due_words.pop_front());
      end
    endfunction
  endclass

endpackage

// ----- bench/tb_graph_traversal_engine_core.sv -----
// ----------------------------------------------------------------------------
// tb_graph_traversal_engine_core
// The bench loads adjacency lists and runs depth-first and breadth-first walks
// through the engine. A directed opening covers the edge cases. Random batches
// follow under several settings and with random gaps on both channels. Every
// result word is checked against the scoreboard's predicted visit order.
// ----------------------------------------------------------------------------
module tb_graph_traversal_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gte_pkg::*;
  import gte_tb_pkg::*;

  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 300;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  gte_in_t         in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  gte_out_t        out_data;
  logic            cfg_we    = 1'b0;
  logic            cfg_idx   = 1'b0;
  logic [CntW-1:0] cfg_data  = '0;

  int              tx_idle_pct = 0;
  int              rx_idle_pct = 0;
  bit              rx_hold_req = 1'b0;
  int              words_sent  = 0;
  logic [CntW-1:0] vcount_now  = CntW'(MaxVertices);

  traversal_scoreboard sb;

  graph_traversal_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: check on accept, then pick the next ready level
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid === 1'b1 && out_ready) sb.check_word(out_data, $time);
      @(negedge clk_i);
      if (rx_hold_req) begin
        hold_left   = HoldCycles;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one word, hold it until accepted
  task automatic send(op_e op, logic [VtxW-1:0] v, logic [VtxW-1:0] nb);
    gte_in_t w;
    w.op       = op;
    w.vertex   = v;
    w.neighbor = nb;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    sb.note_word(w);
    if (op != OpIgnore) words_sent++;
  endtask

  // Drop valid, wait for every pending word, then let the engine go idle
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [CntW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    sb.write_reg(idx, data);
    if (idx == CfgVcount) vcount_now = data;
  endtask

  // Mostly in-range loads and walks, the rest noise
  task automatic random_item();
    int unsigned     live;
    int unsigned     r;
    logic [VtxW-1:0] v;
    logic [VtxW-1:0] nb;
    live = (vcount_now > MaxVertices) ? MaxVertices : vcount_now;
    r    = $urandom_range(99);
    v    = VtxW'($urandom_range(63));
    nb   = VtxW'($urandom_range(63));
    if (r < 4) begin
      send(OpClear, v, nb);
    end else if (r < 62 && live > 0) begin
      send(OpAppend, VtxW'($urandom_range(live - 1)), VtxW'($urandom_range(live - 1)));
    end else if (r < 80 && live > 0) begin
      send(OpTraverse, VtxW'($urandom_range(live - 1)), nb);
    end else if (r < 86) begin
      send(OpIgnore, v, nb);
    end else if (r < 94) begin
      send(OpAppend, v, nb);
    end else begin
      send(OpTraverse, v, nb);
    end
  endtask

  task automatic run_batch(int quota);
    int              start;
    logic [CntW-1:0] vc;
    start = words_sent;
    settle();
    case ($urandom_range(9))
      0:       vc = '0;
      1:       vc = CntW'(1);
      2:       vc = CntW'(2);
      3, 4, 5: vc = CntW'($urandom_range(12, 3));
      6:       vc = CntW'(64);
      7:       vc = CntW'($urandom_range(127, 65));
      8:       vc = CntW'(127);
      default: vc = CntW'($urandom_range(63, 13));
    endcase
    cfg_write(CfgOrder, CntW'($urandom_range(1)));
    cfg_write(CfgVcount, vc);
    // Keep the old lists half the time so stale neighbors show up
    if ($urandom_range(1)) send(OpClear, '0, '0);
    while (words_sent - start < quota) random_item();
  endtask

  // Stall the result side during a long walk while words keep coming
  task automatic fill_and_stall();
    settle();
    cfg_write(CfgOrder, CntW'(1));
    cfg_write(CfgVcount, CntW'(8));
    send(OpClear, '0, '0);
    for (int i = 0; i < 8; i++) begin
      send(OpAppend, VtxW'(i), VtxW'((i + 1) % 8));
      send(OpAppend, VtxW'(i), VtxW'((i + 3) % 8));
    end
    rx_hold_req = 1'b1;
    send(OpTraverse, '0, '0);
    send(OpAppend, '0, VtxW'(2));
    send(OpAppend, VtxW'(7), VtxW'(4));
    send(OpTraverse, VtxW'(3), '0);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, full list, ignored op, both walk orders
    send(OpClear, '0, '0);
    send(OpAppend, '0, VtxW'(63));
    send(OpAppend, VtxW'(63), '0);
    for (int i = 1; i < 8; i++) send(OpAppend, '0, VtxW'(i));
    send(OpAppend, '0, VtxW'(5));
    send(OpTraverse, '0, '0);
    send(OpIgnore, VtxW'(63), VtxW'(63));
    send(OpTraverse, VtxW'(63), VtxW'(63));
    settle();
    cfg_write(CfgOrder, CntW'(1));
    send(OpTraverse, '0, '0);
    // Out-of-range loads and starts, stale neighbors skipped
    settle();
    cfg_write(CfgVcount, CntW'(4));
    send(OpAppend, VtxW'(5), VtxW'(1));
    send(OpAppend, VtxW'(1), VtxW'(5));
    send(OpTraverse, VtxW'(63), '0);
    send(OpTraverse, '0, '0);
    // No vertex in use
    settle();
    cfg_write(CfgVcount, '0);
    send(OpAppend, '0, '0);
    send(OpTraverse, '0, '0);
    // Count above the maximum acts as the maximum
    settle();
    cfg_write(CfgOrder, '0);
    cfg_write(CfgVcount, CntW'(127));
    send(OpTraverse, VtxW'(63), '0);
    send(OpClear, '0, '0);
    send(OpTraverse, VtxW'(5), '0);

    // Random batches under three idle patterns
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct = 68;
        end
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct = 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          fill_and_stall();
        end
      endcase
      repeat (4) run_batch(9);
    end

    settle();
    sb.flush_leftovers($time);
    if (sb.error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/gte_pkg.sv
sv/gte_mem.sv
sv/graph_traversal_engine_core.sv
sv/gte_checker.sv
bench/gte_tb_pkg.sv
bench/tb_graph_traversal_engine_core.sv
